[rtl/dvrsp_pkg.sv]
// Types and constants shared by the DVMRP report stream parser and its checker.
// Depends on nothing; every other file refers to it by scoped names.
package dvrsp_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_ENTRY  = 2'd1,
    PH_NBR    = 2'd2,
    PH_SKIP   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_IFACE   = 2'd1,
    KIND_NBR     = 2'd2,
    KIND_VERDICT = 2'd3
  } kind_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_HDR_ONLY  = 3'd1;
  localparam logic [2:0] ST_SHORT     = 3'd2;
  localparam logic [2:0] ST_NOT_MULT4 = 3'd3;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd4;
  localparam logic [2:0] ST_ZERO_CNT  = 3'd5;
  localparam logic [2:0] ST_TRUNC     = 3'd6;

  // IGMP type 0x13, code 0x06
  localparam logic [15:0] TYPE_CODE = 16'h1306;

  // header byte positions and packet length limits
  localparam int POS_TYPE  = 0;
  localparam int POS_CODE  = 1;
  localparam int POS_CAPS  = 5;
  localparam int POS_MINOR = 6;
  localparam int POS_MAJOR = 7;
  localparam int HDR_LEN   = 8;
  localparam int IFACE_MIN = 20;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  // result payload, last field (addr) in the lowest bits, padded to 96 bits
  typedef struct packed {
    logic [4:0]  pad;
    logic [2:0]  status;
    logic [7:0]  major_ver;
    logic [7:0]  minor_ver;
    logic [7:0]  caps;
    logic [7:0]  nbr_count;
    logic [7:0]  if_flags;
    logic [7:0]  threshold;
    logic [7:0]  metric;
    logic [31:0] addr;
  } rec_data_t;

  typedef struct packed {
    kind_t     kind;
    logic      last;
    rec_data_t data;
  } rec_t;

endpackage

[rtl/dvmrp_report_stream_parser_unit.sv]
// DVMRP Neighbors2 report parser: byte stream in, header/interface/neighbor/verdict records out.
// Depends on dvrsp_pkg for the phase and kind enums, status codes and record types.
//
// A record is written to the result queue as the byte that completes it is taken; out_* shows the head.
// Throughput: one byte per cycle; a byte that closes both a record and the packet yields
// two beats, which a 4-entry result queue drains one per cycle while out_tready is high
// (in_tready drops when fewer than two entries are free).
// Reset: rst_n low at a clock edge clears the parse state and empties the queue.
module dvmrp_report_stream_parser_unit #(
  parameter int LEN_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_packet
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [31:0] addr, [39:32] metric, [47:40] threshold,
                                  // [55:48] if_flags, [63:56] nbr_count, [71:64] caps,
                                  // [79:72] minor_ver, [87:80] major_ver, [90:88] status,
                                  // [95:91] zero
  output logic [1:0]  out_tuser,  // [1:0] rec_kind
  output logic        out_tlast   // last
);

  localparam logic [LEN_BITS-1:0] POS_MAX = {LEN_BITS{1'b1}};
  localparam int PW = dvrsp_pkg::PTR_W;

  // packet parse state
  logic [LEN_BITS-1:0] pos_r, pos_nxt;
  dvrsp_pkg::phase_t   phase_r, phase_nxt;
  logic [2:0]          fbi_r, fbi_nxt;
  logic [7:0]          nl_r, nl_nxt;
  logic [31:0]         as_r, as_nxt;
  logic [31:0]         ef_r, ef_nxt;
  logic [15:0]         htc_r, htc_nxt;
  logic [2:0]          err_r, err_nxt;

  // result queue
  dvrsp_pkg::rec_t mem_r [dvrsp_pkg::FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW:0]     cnt_r;

  logic            in_acc, pop;
  logic            has_rec, has_vd;
  dvrsp_pkg::rec_t rec, vd, slot0, slot1;
  logic            push0, push1;
  logic [2:0]      st;
  logic            trunc;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = cnt_r <= (PW+1)'(dvrsp_pkg::FIFO_DEPTH - 2);
  assign out_tvalid = cnt_r != '0;
  assign pop       = out_tvalid && out_tready;

  // one pass over the accepted byte: update state, build at most one record and a verdict
  always_comb begin
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    fbi_nxt   = fbi_r;
    nl_nxt    = nl_r;
    as_nxt    = as_r;
    ef_nxt    = ef_r;
    htc_nxt   = htc_r;
    err_nxt   = err_r;
    has_rec   = 1'b0;
    has_vd    = 1'b0;
    rec       = '0;
    vd        = '0;
    st        = dvrsp_pkg::ST_OK;
    trunc     = 1'b0;

    if (in_acc) begin
      unique case (phase_r)
        dvrsp_pkg::PH_HEADER: begin
          if (pos_r == LEN_BITS'(dvrsp_pkg::POS_TYPE)) begin
            htc_nxt = {in_tdata, 8'h00};
          end else if (pos_r == LEN_BITS'(dvrsp_pkg::POS_CODE)) begin
            htc_nxt = {htc_r[15:8], in_tdata};
          end else if (pos_r == LEN_BITS'(dvrsp_pkg::POS_CAPS)) begin
            ef_nxt = {24'h0, in_tdata};
          end else if (pos_r == LEN_BITS'(dvrsp_pkg::POS_MINOR)) begin
            ef_nxt = {16'h0, ef_r[7:0], in_tdata};
          end else if (pos_r == LEN_BITS'(dvrsp_pkg::POS_MAJOR)) begin
            has_rec = 1'b1;
            rec.kind = dvrsp_pkg::KIND_HEADER;
            rec.data.caps = ef_r[15:8];
            rec.data.minor_ver = ef_r[7:0];
            rec.data.major_ver = in_tdata;
            ef_nxt  = '0;
            fbi_nxt = '0;
            phase_nxt = (htc_r == dvrsp_pkg::TYPE_CODE) ? dvrsp_pkg::PH_ENTRY
                                                        : dvrsp_pkg::PH_SKIP;
          end
        end
        dvrsp_pkg::PH_ENTRY: begin
          // address bytes first, then metric, threshold, flags, count
          if (!fbi_r[2]) as_nxt = {as_r[23:0], in_tdata};
          else           ef_nxt = {ef_r[23:0], in_tdata};
          if (fbi_r == 3'd7 && !in_tlast) begin
            has_rec = 1'b1;
            rec.kind = dvrsp_pkg::KIND_IFACE;
            rec.data.addr      = as_nxt;
            rec.data.metric    = ef_nxt[31:24];
            rec.data.threshold = ef_nxt[23:16];
            rec.data.if_flags  = ef_nxt[15:8];
            rec.data.nbr_count = ef_nxt[7:0];
            fbi_nxt = '0;
            if (ef_nxt[7:0] == 8'h00) begin
              err_nxt   = dvrsp_pkg::ST_ZERO_CNT;
              phase_nxt = dvrsp_pkg::PH_SKIP;
            end else begin
              nl_nxt    = ef_nxt[7:0];
              phase_nxt = dvrsp_pkg::PH_NBR;
            end
          end else begin
            fbi_nxt = fbi_r + 3'd1;
          end
        end
        dvrsp_pkg::PH_NBR: begin
          as_nxt = {as_r[23:0], in_tdata};
          if (fbi_r >= 3'd3) begin
            has_rec = 1'b1;
            rec.kind = dvrsp_pkg::KIND_NBR;
            rec.data.addr = as_nxt;
            fbi_nxt = '0;
            nl_nxt  = nl_r - 8'd1;
            if (nl_nxt == 8'h00) phase_nxt = dvrsp_pkg::PH_ENTRY;
          end else begin
            fbi_nxt = fbi_r + 3'd1;
          end
        end
        dvrsp_pkg::PH_SKIP: begin
          // drop the rest of the packet
        end
        default: begin
        end
      endcase

      if (in_tlast) begin
        trunc = (phase_r == dvrsp_pkg::PH_ENTRY) || (phase_nxt == dvrsp_pkg::PH_NBR);
        priority if (pos_r < LEN_BITS'(dvrsp_pkg::HDR_LEN - 1)) begin
          st = dvrsp_pkg::ST_SHORT;
        end else if (pos_r == POS_MAX || pos_r[1:0] != 2'b11) begin
          st = dvrsp_pkg::ST_NOT_MULT4;
        end else if (htc_nxt != dvrsp_pkg::TYPE_CODE) begin
          st = dvrsp_pkg::ST_BAD_TYPE;
        end else if (pos_r < LEN_BITS'(dvrsp_pkg::IFACE_MIN - 1)) begin
          st = dvrsp_pkg::ST_HDR_ONLY;
        end else if (err_nxt != 3'd0) begin
          st = err_nxt;
        end else if (trunc) begin
          st = dvrsp_pkg::ST_TRUNC;
        end else begin
          st = dvrsp_pkg::ST_OK;
        end
        has_vd = 1'b1;
        vd.kind = dvrsp_pkg::KIND_VERDICT;
        vd.last = 1'b1;
        vd.data.status = st;
        // return to the start-of-packet state
        pos_nxt   = '0;
        phase_nxt = dvrsp_pkg::PH_HEADER;
        fbi_nxt   = '0;
        nl_nxt    = '0;
        as_nxt    = '0;
        ef_nxt    = '0;
        htc_nxt   = '0;
        err_nxt   = '0;
      end else begin
        pos_nxt = (pos_r < POS_MAX) ? pos_r + LEN_BITS'(1) : POS_MAX;
      end
      rec.last = !has_vd;
    end
  end

  // first queue slot takes the record, or the verdict alone; second only the verdict
  always_comb begin
    slot0 = has_rec ? rec : vd;
    slot1 = vd;
    push0 = has_rec || has_vd;
    push1 = has_rec && has_vd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= dvrsp_pkg::PH_HEADER;
      fbi_r   <= '0;
      nl_r    <= '0;
      as_r    <= '0;
      ef_r    <= '0;
      htc_r   <= '0;
      err_r   <= '0;
    end else begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      fbi_r   <= fbi_nxt;
      nl_r    <= nl_nxt;
      as_r    <= as_nxt;
      ef_r    <= ef_nxt;
      htc_r   <= htc_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) mem_r[wr_ptr_r] <= slot0;
    if (push1) mem_r[wr_ptr_r + PW'(1)] <= slot1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PW'(push0) + PW'(push1);
      if (pop) rd_ptr_r <= rd_ptr_r + PW'(1);
      cnt_r <= cnt_r + (PW+1)'(push0) + (PW+1)'(push1) - (PW+1)'(pop);
    end
  end

  assign out_tdata = mem_r[rd_ptr_r].data;
  assign out_tuser = mem_r[rd_ptr_r].kind;
  assign out_tlast = mem_r[rd_ptr_r].last;

endmodule

[rtl/dvrsp_checker.sv]
// Port-level checker for the DVMRP report stream parser, bound to its top level.
// Depends on dvrsp_pkg for the record layout, kind and status codes.
module dvrsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  dvrsp_pkg::rec_data_t d;
  assign d = out_tdata;

  // hold a stalled beat
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

  // empty the queue on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat shown right after reset");

  // a verdict always closes the results of its byte and carries a defined code
  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == dvrsp_pkg::KIND_VERDICT |->
      out_tlast && d.status <= dvrsp_pkg::ST_TRUNC && d.addr == 32'h0)
    else $error("malformed verdict beat");

  // only verdicts carry a status, only headers carry version bytes
  a_field_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != dvrsp_pkg::KIND_VERDICT |->
      d.status == 3'd0 && d.pad == 5'd0 &&
      (out_tuser == dvrsp_pkg::KIND_HEADER ||
       (d.caps == 8'h0 && d.minor_ver == 8'h0 && d.major_ver == 8'h0)))
    else $error("record carries a field of another kind");

endmodule

bind dvmrp_report_stream_parser_unit dvrsp_checker u_dvrsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[sim/dvmrp_report_stream_parser_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for dvmrp_report_stream_parser_unit: directed and random report
// payloads go in as beats, and a built-in parser predicts every record coming back.
// Depends on dvrsp_pkg and the unit; needs no files or arguments.
module dvmrp_report_stream_parser_unit_test;

  localparam int LEN_BITS = 16;
  localparam int unsigned POS_MAX = (1 << LEN_BITS) - 1;
  localparam int RANDOM_BYTES = 1500;
  localparam int HOLDOFF_CYCLES = 300;

  // one pending input beat, or a marker that makes the sender wait for all records
  typedef struct packed {
    logic [7:0] b;
    logic       eop;
    logic       drain;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tlast = 1'b0;    // end_of_packet
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;          // [31:0] addr ... [90:88] status, [95:91] zero
  logic [1:0]  out_tuser;          // [1:0] rec_kind
  logic        out_tlast;          // last

  beat_t            pend_q[$];     // beats still to be offered
  dvrsp_pkg::rec_t  rec_q[$];      // records predicted but not yet seen
  logic [7:0]       pkt[$];        // packet under construction

  int mismatches = 0;
  int bytes_taken = 0;
  int records_seen = 0;
  int stim_bytes = 0;

  // parser state mirrored from the unit
  logic [15:0]         pos_r = '0;
  dvrsp_pkg::phase_t   phase_r = dvrsp_pkg::PH_HEADER;
  logic [2:0]          fidx_r = '0;
  logic [7:0]          nleft_r = '0;
  logic [31:0]         shift_r = '0;
  logic [31:0]         fields_r = '0;
  logic [15:0]         tcode_r = '0;
  logic [2:0]          ierr_r = dvrsp_pkg::ST_OK;

  dvmrp_report_stream_parser_unit #(
    .LEN_BITS(LEN_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hold reset low from the start, then release it for good.
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Drop back to the header phase with all packet state cleared.
  task automatic clear_parse();
    pos_r = '0;
    phase_r = dvrsp_pkg::PH_HEADER;
    fidx_r = '0;
    nleft_r = '0;
    shift_r = '0;
    fields_r = '0;
    tcode_r = '0;
    ierr_r = dvrsp_pkg::ST_OK;
  endtask

  // Advance the mirrored parser by one accepted byte and queue the records it yields.
  task automatic parse_byte(input logic [7:0] b, input logic eop);
    dvrsp_pkg::rec_t   recs[2];
    dvrsp_pkg::phase_t ph0;
    int unsigned       pos;
    int unsigned       total;
    logic [2:0]        idx;
    logic [2:0]        st;
    bit                trunc;
    int                n;
    n = 0;
    pos = pos_r;
    ph0 = phase_r;
    idx = fidx_r;
    recs[0] = '0;
    recs[1] = '0;
    case (phase_r)
      dvrsp_pkg::PH_HEADER: begin
        if (pos == dvrsp_pkg::POS_TYPE) begin
          tcode_r = {b, 8'h00};
        end else if (pos == dvrsp_pkg::POS_CODE) begin
          tcode_r[7:0] = b;
        end else if (pos == dvrsp_pkg::POS_CAPS) begin
          fields_r = {24'h0, b};
        end else if (pos == dvrsp_pkg::POS_MINOR) begin
          fields_r = {16'h0, fields_r[7:0], b};
        end else if (pos == dvrsp_pkg::POS_MAJOR) begin
          recs[n].kind = dvrsp_pkg::KIND_HEADER;
          recs[n].data.caps = fields_r[15:8];
          recs[n].data.minor_ver = fields_r[7:0];
          recs[n].data.major_ver = b;
          n++;
          fields_r = '0;
          fidx_r = '0;
          phase_r = (tcode_r == dvrsp_pkg::TYPE_CODE) ? dvrsp_pkg::PH_ENTRY
                                                       : dvrsp_pkg::PH_SKIP;
        end
      end
      dvrsp_pkg::PH_ENTRY: begin
        if (idx < 4) shift_r = {shift_r[23:0], b};
        else fields_r = {fields_r[23:0], b};
        // an end on the entry's last byte gives no interface record
        if (idx == 3'd7 && !eop) begin
          recs[n].kind = dvrsp_pkg::KIND_IFACE;
          recs[n].data.addr = shift_r;
          recs[n].data.metric = fields_r[31:24];
          recs[n].data.threshold = fields_r[23:16];
          recs[n].data.if_flags = fields_r[15:8];
          recs[n].data.nbr_count = fields_r[7:0];
          n++;
          fidx_r = '0;
          if (fields_r[7:0] == 8'h00) begin
            ierr_r = dvrsp_pkg::ST_ZERO_CNT;
            phase_r = dvrsp_pkg::PH_SKIP;
          end else begin
            nleft_r = fields_r[7:0];
            phase_r = dvrsp_pkg::PH_NBR;
          end
        end else begin
          fidx_r = idx + 3'd1;
        end
      end
      dvrsp_pkg::PH_NBR: begin
        shift_r = {shift_r[23:0], b};
        if (idx >= 3) begin
          recs[n].kind = dvrsp_pkg::KIND_NBR;
          recs[n].data.addr = shift_r;
          n++;
          fidx_r = '0;
          nleft_r = nleft_r - 8'd1;
          if (nleft_r == 8'd0) phase_r = dvrsp_pkg::PH_ENTRY;
        end else begin
          fidx_r = idx + 3'd1;
        end
      end
      default: ;
    endcase

    if (eop) begin
      total = pos + 1;
      trunc = (ph0 == dvrsp_pkg::PH_ENTRY) || (phase_r == dvrsp_pkg::PH_NBR);
      if (total < dvrsp_pkg::HDR_LEN) st = dvrsp_pkg::ST_SHORT;
      else if (pos >= POS_MAX || total[1:0] != 2'b00) st = dvrsp_pkg::ST_NOT_MULT4;
      else if (tcode_r != dvrsp_pkg::TYPE_CODE) st = dvrsp_pkg::ST_BAD_TYPE;
      else if (total < dvrsp_pkg::IFACE_MIN) st = dvrsp_pkg::ST_HDR_ONLY;
      else if (ierr_r != dvrsp_pkg::ST_OK) st = ierr_r;
      else if (trunc) st = dvrsp_pkg::ST_TRUNC;
      else st = dvrsp_pkg::ST_OK;
      recs[n].kind = dvrsp_pkg::KIND_VERDICT;
      recs[n].data.status = st;
      n++;
      clear_parse();
    end else begin
      pos_r = (pos < POS_MAX) ? pos_r + 16'd1 : pos_r;
    end

    if (n > 0) recs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) rec_q.push_back(recs[i]);
  endtask

  function automatic void cmp_field(string what, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  task automatic put_hdr(input logic [7:0] t, input logic [7:0] c, input logic [7:0] caps,
                         input logic [7:0] mi, input logic [7:0] ma);
    pkt.push_back(t);
    pkt.push_back(c);
    pkt.push_back(8'($urandom));  // checksum, ignored
    pkt.push_back(8'($urandom));
    pkt.push_back(8'($urandom));  // reserved
    pkt.push_back(caps);
    pkt.push_back(mi);
    pkt.push_back(ma);
  endtask

  task automatic put_good_hdr();
    put_hdr(8'h13, 8'h06, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic put_entry(input logic [31:0] a, input logic [7:0] m, input logic [7:0] th,
                           input logic [7:0] f, input logic [7:0] cnt);
    pkt.push_back(a[31:24]);
    pkt.push_back(a[23:16]);
    pkt.push_back(a[15:8]);
    pkt.push_back(a[7:0]);
    pkt.push_back(m);
    pkt.push_back(th);
    pkt.push_back(f);
    pkt.push_back(cnt);
  endtask

  task automatic put_rand(input int nbytes);
    for (int i = 0; i < nbytes; i++) pkt.push_back(8'($urandom));
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) pkt.push_back(w[8*i +: 8]);
  endtask

  // Move the finished packet onto the pending queue, end mark on its final byte.
  task automatic send_pkt();
    beat_t bt;
    for (int i = 0; i < pkt.size(); i++) begin
      bt.b = pkt[i];
      bt.eop = (i == pkt.size() - 1);
      bt.drain = 1'b0;
      pend_q.push_back(bt);
    end
    stim_bytes += pkt.size();
    pkt.delete();
  endtask

  task automatic wait_drained();
    beat_t bt;
    bt = '0;
    bt.drain = 1'b1;
    pend_q.push_back(bt);
  endtask

  // Mostly well-formed reports with random content; some only random bytes, some cut
  // short, some with a wrong header, a few with a zero count.
  task automatic build_random_pkt();
    int nif;
    int cnt;
    int cut;
    if ($urandom_range(99) < 10) begin
      put_rand($urandom_range(1, 40));
    end else begin
      if ($urandom_range(99) < 6) put_hdr(8'($urandom), 8'($urandom), 8'($urandom),
                                           8'($urandom), 8'($urandom));
      else put_good_hdr();
      nif = $urandom_range(0, 3);
      for (int i = 0; i < nif; i++) begin
        if ($urandom_range(99) < 5) cnt = 0;
        else cnt = $urandom_range(1, 3);
        put_entry($urandom, 8'($urandom), 8'($urandom), 8'($urandom), 8'(cnt));
        put_rand(4 * cnt);
      end
      if ($urandom_range(99) < 8) put_rand(4);
      if ($urandom_range(99) < 20) begin
        cut = $urandom_range(1, pkt.size());
        while (pkt.size() > cut) void'(pkt.pop_back());
      end
    end
    send_pkt();
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : drive_proc
    logic  nv;
    beat_t nb;
    bit    idle;
    nv = in_tvalid;
    nb.b = in_tdata;
    nb.eop = in_tlast;
    nb.drain = 1'b0;
    if (!rst_n) begin
      nv = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        parse_byte(in_tdata, in_tlast);
        bytes_taken++;
      end
      // hold a beat the unit has not taken yet
      if (!(in_tvalid && !in_tready)) begin
        nv = 1'b0;
        if (pend_q.size() > 0 && pend_q[0].drain) begin
          if (rec_q.size() == 0) void'(pend_q.pop_front());
        end else if (pend_q.size() > 0) begin
          // no random gaps while bytes 500..799 go in
          idle = (bytes_taken < 500 || bytes_taken >= 800) && ($urandom_range(99) < 25);
          if (!idle) begin
            nb = pend_q.pop_front();
            nv = 1'b1;
          end
        end
      end
    end
    in_tvalid <= nv;
    in_tdata <= nb.b;
    in_tlast <= nb.eop;
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : watch_proc
    dvrsp_pkg::rec_t      want;
    dvrsp_pkg::rec_data_t got;
    logic                 rdy;
    int                   hold_left;
    bit                   held;
    if (!rst_n) begin
      rdy = 1'b0;
      hold_left = 0;
      held = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        records_seen++;
        if (rec_q.size() == 0) begin
          $display("%0t: record with none expected, actual kind %0d data %0h", $time,
                   out_tuser, out_tdata);
          mismatches++;
        end else begin
          want = rec_q.pop_front();
          got = dvrsp_pkg::rec_data_t'(out_tdata);
          cmp_field("rec_kind", 32'(want.kind), 32'(out_tuser));
          cmp_field("last", 32'(want.last), 32'(out_tlast));
          cmp_field("addr", want.data.addr, got.addr);
          cmp_field("metric", 32'(want.data.metric), 32'(got.metric));
          cmp_field("threshold", 32'(want.data.threshold), 32'(got.threshold));
          cmp_field("if_flags", 32'(want.data.if_flags), 32'(got.if_flags));
          cmp_field("nbr_count", 32'(want.data.nbr_count), 32'(got.nbr_count));
          cmp_field("caps", 32'(want.data.caps), 32'(got.caps));
          cmp_field("minor_ver", 32'(want.data.minor_ver), 32'(got.minor_ver));
          cmp_field("major_ver", 32'(want.data.major_ver), 32'(got.major_ver));
          cmp_field("status", 32'(want.data.status), 32'(got.status));
          cmp_field("pad", 32'(want.data.pad), 32'(got.pad));
        end
      end
      // back off once for a long stretch so the result queue fills and in_tready drops
      if (!held && records_seen >= 150) begin
        held = 1'b1;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (records_seen >= 300 && records_seen < 550) begin
        rdy = 1'b1;
      end else begin
        rdy = ($urandom_range(99) >= 25);
      end
    end
    out_tready <= rdy;
  end

  // ---------------------------------------------------------------- stimulus and end

  initial begin
    // short: one byte, then seven
    pkt.push_back(8'hFF);
    send_pkt();
    put_rand(0);
    for (int i = 0; i < 7; i++) pkt.push_back(8'hFF);
    send_pkt();
    // header only, at 8 and at 12 bytes
    put_hdr(8'h13, 8'h06, 8'hFF, 8'h00, 8'hFF);
    send_pkt();
    put_hdr(8'h13, 8'h06, 8'h00, 8'hFF, 8'h00);
    put_word(32'hFFFF_FFFF);
    send_pkt();
    // wrong code: header record still comes out
    put_hdr(8'h13, 8'h07, 8'hA5, 8'h5A, 8'h01);
    send_pkt();
    // wrong type with a length not a multiple of four
    put_hdr(8'h12, 8'h06, 8'h00, 8'h00, 8'h00);
    put_rand(2);
    send_pkt();
    // zero neighbor count
    put_good_hdr();
    put_entry(32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 8'h00);
    put_word(32'h0102_0304);
    send_pkt();
    // clean report with one neighbor
    put_good_hdr();
    put_entry(32'h0000_0000, 8'hFF, 8'hFF, 8'hFF, 8'h01);
    put_word(32'hFFFF_FFFF);
    send_pkt();
    // end before the last neighbor
    put_good_hdr();
    put_entry($urandom, 8'h01, 8'h40, 8'h02, 8'h02);
    put_word($urandom);
    send_pkt();
    // end on the final byte of an entry header
    put_good_hdr();
    put_entry($urandom, 8'h01, 8'h01, 8'h00, 8'h01);
    put_word($urandom);
    put_entry($urandom, 8'h02, 8'h02, 8'h00, 8'h01);
    send_pkt();
    // end in the middle of an entry header
    put_good_hdr();
    put_entry($urandom, 8'h03, 8'h03, 8'h00, 8'h01);
    put_word($urandom);
    put_word($urandom);
    send_pkt();
    wait_drained();
    // full 255-neighbor entry, runs the neighbor counter down from its top value
    put_good_hdr();
    put_entry($urandom, 8'($urandom), 8'($urandom), 8'($urandom), 8'hFF);
    put_rand(4 * 255);
    send_pkt();

    while (stim_bytes < RANDOM_BYTES) begin
      build_random_pkt();
      if ($urandom_range(99) < 4) wait_drained();
    end
    build_random_pkt();

    while (!rst_n) @(posedge clk);
    while (pend_q.size() != 0 || in_tvalid) @(posedge clk);
    while (rec_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Give up well past the slowest legal run.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
